// ----- rtl/spdt_pkg.sv -----
`default_nettype none
package spdt_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 32;

	localparam logic [BYTE_W-1:0] OP_PUSH_MIN  = 8'h01;
	localparam logic [BYTE_W-1:0] OP_PUSH_MAX  = 8'h4b;
	localparam logic [BYTE_W-1:0] OP_PUSH_LEN1 = 8'h4c;
	localparam logic [BYTE_W-1:0] OP_PUSH_LEN2 = 8'h4d;
	localparam logic [BYTE_W-1:0] OP_PUSH_LEN4 = 8'h4e;

	localparam int unsigned OUT_DATA_W = 80;

	typedef enum logic [1:0] {
		PH_OPCODE  = 2'd0,
		PH_LENGTH  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ROLE_PLAIN = 2'd0,
		ROLE_PUSH  = 2'd1,
		ROLE_LEN   = 2'd2,
		ROLE_DATA  = 2'd3
	} role_t;

	typedef struct packed {
		phase_t            phase;
		logic [2:0]        len_left;
		logic [1:0]        len_shift;
		logic [LEN_W-1:0]  len_accum;
		logic [LEN_W-1:0]  payload_left;
		logic [BYTE_W-1:0] held_opcode;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase:        PH_OPCODE,
		len_left:     3'd0,
		len_shift:    2'd0,
		len_accum:    '0,
		payload_left: '0,
		held_opcode:  '0
	};

	typedef struct packed {
		role_t             role;
		logic [BYTE_W-1:0] opcode;
		logic [LEN_W-1:0]  push_length;
		logic [LEN_W-1:0]  bytes_left;
		logic              element_done;
		logic              truncated;
		logic              script_end;
	} token_t;

endpackage
`default_nettype wire

// ----- rtl/spdt_step.sv -----
`default_nettype none
module spdt_step import spdt_pkg::*; (
	input  wire parse_state_t      cur,
	input  wire logic [BYTE_W-1:0] script_byte,
	input  wire logic              last_byte,
	output parse_state_t           nxt,
	output token_t                 tok
);

	parse_state_t     upd;
	logic [LEN_W-1:0] accum_new;
	logic [2:0]       len_left_new;
	logic [LEN_W-1:0] pay_new;

	always_comb begin
		accum_new    = cur.len_accum
			| ({{(LEN_W-BYTE_W){1'b0}}, script_byte} << {cur.len_shift, 3'b000});
		len_left_new = cur.len_left - 3'd1;
		pay_new      = cur.payload_left - {{(LEN_W-1){1'b0}}, 1'b1};

		upd              = cur;
		tok.role         = ROLE_PLAIN;
		tok.push_length  = '0;
		tok.bytes_left   = '0;
		tok.element_done = 1'b0;

		case (cur.phase)
			PH_LENGTH: begin
				tok.role        = ROLE_LEN;
				upd.len_accum   = accum_new;
				upd.len_shift   = cur.len_shift + 2'd1;
				upd.len_left    = len_left_new;
				tok.push_length = accum_new;
				if (len_left_new == 3'd0) begin
					tok.bytes_left = accum_new;
					if (accum_new == '0) begin
						tok.element_done = 1'b1;
						upd.phase        = PH_OPCODE;
					end else begin
						upd.payload_left = accum_new;
						upd.phase        = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				tok.role         = ROLE_DATA;
				upd.payload_left = pay_new;
				tok.push_length  = cur.len_accum;
				tok.bytes_left   = pay_new;
				if (pay_new == '0) begin
					tok.element_done = 1'b1;
					upd.phase        = PH_OPCODE;
				end
			end
			default: begin
				upd.held_opcode = script_byte;
				if (script_byte >= OP_PUSH_MIN && script_byte <= OP_PUSH_MAX) begin
					tok.role         = ROLE_PUSH;
					upd.len_accum    = {{(LEN_W-BYTE_W){1'b0}}, script_byte};
					upd.payload_left = {{(LEN_W-BYTE_W){1'b0}}, script_byte};
					tok.push_length  = {{(LEN_W-BYTE_W){1'b0}}, script_byte};
					tok.bytes_left   = {{(LEN_W-BYTE_W){1'b0}}, script_byte};
					upd.phase        = PH_PAYLOAD;
				end else if (script_byte == OP_PUSH_LEN1) begin
					tok.role      = ROLE_PUSH;
					upd.len_accum = '0;
					upd.len_shift = 2'd0;
					upd.len_left  = 3'd1;
					upd.phase     = PH_LENGTH;
				end else if (script_byte == OP_PUSH_LEN2) begin
					tok.role      = ROLE_PUSH;
					upd.len_accum = '0;
					upd.len_shift = 2'd0;
					upd.len_left  = 3'd2;
					upd.phase     = PH_LENGTH;
				end else if (script_byte == OP_PUSH_LEN4) begin
					tok.role      = ROLE_PUSH;
					upd.len_accum = '0;
					upd.len_shift = 2'd0;
					upd.len_left  = 3'd4;
					upd.phase     = PH_LENGTH;
				end else begin
					tok.element_done = 1'b1;
					upd.phase        = PH_OPCODE;
				end
			end
		endcase

		tok.opcode     = upd.held_opcode;
		tok.truncated  = last_byte && (upd.phase != PH_OPCODE);
		tok.script_end = last_byte;
		nxt            = last_byte ? STATE_RESET : upd;
	end

endmodule
`default_nettype wire

// ----- rtl/script_push_data_tokenizer_top.sv -----
// An accepted word is registered in stage s1; its token is registered in stage s2.
// Throughput: one word per cycle absent master stalls; one parse-state pass per word.
// Stalls on the master side hold both registers and back-pressure the slave side.
// Reset: arst_n asynchronous, active low; clears valid flags and the parse state.
// After any word with tlast the parse state returns to its reset value.
`default_nettype none
module script_push_data_tokenizer_top import spdt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [BYTE_W-1:0]     s_tdata,  // [7:0] script_byte
	input  wire logic                  s_tlast,  // last_byte
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // [7:0] current_opcode, [39:8] push_length,
	                                             // [71:40] bytes_left, [72] element_done,
	                                             // [73] truncated, [79:74] zero
	output logic [1:0]                 m_tuser,  // [1:0] byte_role
	output logic                       m_tlast   // script_end
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	parse_state_t      state_q;
	parse_state_t      state_nxt;
	token_t            tok;
	logic              valid_s2;
	token_t            tok_s2;
	logic              advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	spdt_step u_step (
		.cur         (state_q),
		.script_byte (byte_s1),
		.last_byte   (last_s1),
		.nxt         (state_nxt),
		.tok         (tok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				state_q  <= state_nxt;
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (advance) begin
			tok_s2 <= tok;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = tok_s2.role;
	assign m_tlast  = tok_s2.script_end;
	assign m_tdata  = {6'd0, tok_s2.truncated, tok_s2.element_done, tok_s2.bytes_left,
		tok_s2.push_length, tok_s2.opcode};

endmodule
`default_nettype wire

// ----- rtl/spdt_checker.sv -----
`default_nettype none
module spdt_checker import spdt_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic [1:0]            m_tuser,
	input wire logic                  m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("master word changed while stalled");

	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[73] |-> m_tlast && !m_tdata[72])
		else $error("truncation without script end or with element done");

	a_plain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ROLE_PLAIN |-> m_tdata[72] && m_tdata[71:8] == '0)
		else $error("plain opcode with length or open element");

	a_data_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ROLE_DATA |-> m_tdata[72] == (m_tdata[71:40] == '0))
		else $error("payload done flag disagrees with bytes left");

endmodule

bind script_push_data_tokenizer_top spdt_checker u_spdt_checker (.*);
`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none
module testbench;
	import spdt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT = 1000;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata  = '0;
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	token_t      expected_tokens[$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles   = 0;
	bit          allow_gaps     = 1'b1;

	phase_t             parse_phase;
	logic [2:0]         len_pending;
	logic [1:0]         len_shift;
	logic [LEN_W-1:0]   len_accum;
	logic [LEN_W-1:0]   payload_pending;
	logic [BYTE_W-1:0]  held_opcode;

	script_push_data_tokenizer_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void reset_parser();
		parse_phase     = PH_OPCODE;
		len_pending     = '0;
		len_shift       = '0;
		len_accum       = '0;
		payload_pending = '0;
		held_opcode     = '0;
	endfunction

	function automatic token_t tokenize_byte(input logic [7:0] b, input logic last);
		token_t t;
		t = '0;
		case (parse_phase)
			PH_LENGTH: begin
				t.role = ROLE_LEN;
				len_accum = len_accum | ({24'd0, b} << {len_shift, 3'b000});
				len_shift = len_shift + 2'd1;
				len_pending = len_pending - 3'd1;
				t.push_length = len_accum;
				if (len_pending == 3'd0) begin
					t.bytes_left = len_accum;
					if (len_accum == '0) begin
						t.element_done = 1'b1;
						parse_phase = PH_OPCODE;
					end else begin
						payload_pending = len_accum;
						parse_phase = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				t.role = ROLE_DATA;
				payload_pending = payload_pending - 32'd1;
				t.push_length = len_accum;
				t.bytes_left = payload_pending;
				if (payload_pending == '0) begin
					t.element_done = 1'b1;
					parse_phase = PH_OPCODE;
				end
			end
			default: begin
				held_opcode = b;
				if (b >= OP_PUSH_MIN && b <= OP_PUSH_MAX) begin
					t.role = ROLE_PUSH;
					len_accum = {24'd0, b};
					payload_pending = {24'd0, b};
					t.push_length = {24'd0, b};
					t.bytes_left = {24'd0, b};
					parse_phase = PH_PAYLOAD;
				end else if (b >= OP_PUSH_LEN1 && b <= OP_PUSH_LEN4) begin
					t.role = ROLE_PUSH;
					len_accum = '0;
					len_shift = '0;
					case (b)
						OP_PUSH_LEN1: len_pending = 3'd1;
						OP_PUSH_LEN2: len_pending = 3'd2;
						default:      len_pending = 3'd4;
					endcase
					parse_phase = PH_LENGTH;
				end else begin
					t.role = ROLE_PLAIN;
					t.element_done = 1'b1;
					parse_phase = PH_OPCODE;
				end
			end
		endcase
		t.opcode = held_opcode;
		t.truncated = last && (parse_phase != PH_OPCODE);
		t.script_end = last;
		if (last)
			reset_parser();
		return t;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (allow_gaps && $urandom_range(0, 99) < 7) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_tokens.insert(expected_tokens.size(), tokenize_byte(b, last));
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_random_scripts(input int unsigned n_bytes);
		logic [7:0]  script_q[$];
		logic [7:0]  op;
		logic [31:0] plen;
		int unsigned sent;
		int unsigned kind;
		int unsigned n_len;
		int unsigned n_data;
		int unsigned cut;
		bit          open_end;
		sent = 0;
		while (sent < n_bytes) begin
			script_q.delete();
			open_end = 1'b0;
			kind = $urandom_range(0, 99);
			if (kind < 10) begin
				repeat ($urandom_range(1, 12))
					script_q.insert(script_q.size(), 8'($urandom()));
			end else begin
				repeat ($urandom_range(1, 6)) begin
					if (!open_end) begin
						case ($urandom_range(0, 9))
							0, 1, 2: begin
								if ($urandom_range(0, 3) == 0)
									op = 8'h00;
								else
									op = 8'($urandom_range(8'h4f, 8'hff));
								script_q.insert(script_q.size(), op);
							end
							3, 4, 5: begin
								if ($urandom_range(0, 3) == 0)
									n_data = $urandom_range(OP_PUSH_MIN, OP_PUSH_MAX);
								else
									n_data = $urandom_range(1, 6);
								script_q.insert(script_q.size(), 8'(n_data));
								repeat (n_data)
									script_q.insert(script_q.size(), 8'($urandom()));
							end
							6, 7, 8: begin
								op = 8'(OP_PUSH_LEN1 + $urandom_range(0, 2));
								if ($urandom_range(0, 7) == 0)
									plen = $urandom_range(0, 255);
								else
									plen = $urandom_range(0, 6);
								n_len = (op == OP_PUSH_LEN1) ? 1 : (op == OP_PUSH_LEN2) ? 2 : 4;
								script_q.insert(script_q.size(), op);
								for (int k = 0; k < n_len; k++)
									script_q.insert(script_q.size(), plen[8*k +: 8]);
								repeat (plen)
									script_q.insert(script_q.size(), 8'($urandom()));
							end
							default: begin
								// huge declared length, end the script mid-payload
								op = $urandom_range(0, 1) ? OP_PUSH_LEN2 : OP_PUSH_LEN4;
								plen = $urandom();
								n_len = (op == OP_PUSH_LEN2) ? 2 : 4;
								script_q.insert(script_q.size(), op);
								for (int k = 0; k < n_len; k++)
									script_q.insert(script_q.size(), plen[8*k +: 8]);
								repeat ($urandom_range(0, 3))
									script_q.insert(script_q.size(), 8'($urandom()));
								open_end = 1'b1;
							end
						endcase
					end
				end
				if (kind < 25) begin
					cut = $urandom_range(1, script_q.size());
					while (script_q.size() > cut) void'(script_q.pop_back());
				end
			end
			foreach (script_q[i])
				send_byte(script_q[i], i == script_q.size() - 1);
			sent += script_q.size();
		end
	endtask

	task automatic test_plain_opcodes();
		allow_gaps = 1'b1;
		send_byte(8'h00, 1'b0);
		send_byte(8'h4f, 1'b0);
		send_byte(8'hff, 1'b1);
	endtask

	task automatic test_implicit_push();
		allow_gaps = 1'b1;
		send_byte(OP_PUSH_MIN, 1'b0);
		send_byte(8'haa, 1'b0);
		send_byte(OP_PUSH_MAX, 1'b0);
		send_byte(8'h5c, 1'b1);
		send_byte(OP_PUSH_MIN, 1'b0);
		send_byte(8'h7e, 1'b1);
	endtask

	task automatic test_pushdata_lengths();
		allow_gaps = 1'b1;
		send_byte(OP_PUSH_LEN1, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(OP_PUSH_LEN1, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b0);
		send_byte(OP_PUSH_LEN2, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h5a, 1'b1);
	endtask

	task automatic test_truncation();
		allow_gaps = 1'b1;
		send_byte(OP_PUSH_LEN4, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(OP_PUSH_LEN2, 1'b0);
		send_byte(8'h05, 1'b1);
	endtask

	task automatic test_random_scripts(input int unsigned n_bytes);
		allow_gaps = 1'b1;
		send_random_scripts(n_bytes);
	endtask

	task automatic test_back_to_back(input int unsigned n_bytes);
		allow_gaps = 1'b0;
		send_random_scripts(n_bytes);
		allow_gaps = 1'b1;
	endtask

	task automatic compare_field(input string field, input logic [31:0] want_v,
	                             input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h",
			         $time, field, want_v, got_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		m_tready <= !allow_gaps || ($urandom_range(0, 99) >= 7);
	end

	always @(posedge clk) begin : check_words
		token_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_tokens.size() == 0) begin
				$display("%0t ns: unexpected word, expected none, actual %h",
				         $time, m_tdata);
				mismatch_count++;
			end else begin
				want = expected_tokens.pop_front();
				compare_field("byte_role",      32'(want.role),         32'(m_tuser));
				compare_field("current_opcode", 32'(want.opcode),       32'(m_tdata[7:0]));
				compare_field("push_length",    want.push_length,       m_tdata[39:8]);
				compare_field("bytes_left",     want.bytes_left,        m_tdata[71:40]);
				compare_field("element_done",   32'(want.element_done), 32'(m_tdata[72]));
				compare_field("truncated",      32'(want.truncated),    32'(m_tdata[73]));
				compare_field("script_end",     32'(want.script_end),   32'(m_tlast));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t ns: timeout, no word moved", $time);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		reset_parser();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_opcodes();
		test_implicit_push();
		test_pushdata_lengths();
		test_truncation();
		wait_for_results();
		test_random_scripts(700);
		wait_for_results();
		test_back_to_back(300);
		test_random_scripts(300);
		wait_for_results();
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/spdt_pkg.sv
rtl/spdt_step.sv
rtl/script_push_data_tokenizer_top.sv
rtl/spdt_checker.sv
tb/testbench.sv
